// ===== hw/rtl/all_pairs_shortest_path_unit_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ALL_PAIRS_SHORTEST_PATH_UNIT_MACROS_SVH
`define ALL_PAIRS_SHORTEST_PATH_UNIT_MACROS_SVH

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define APSP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Whenever the antecedent holds, the consequent holds in the next cycle.
`define APSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/apsp_pkg.sv =====
`default_nettype none
package apsp_pkg;
    localparam int MAX_NODES   = 16;
    localparam int NODE_BITS   = 4;
    localparam int COUNT_BITS  = 5;
    localparam int WEIGHT_BITS = 16;
    localparam int DIST_BITS   = 20;

    typedef logic [DIST_BITS-1:0]  dist_t;
    typedef logic [NODE_BITS-1:0]  node_t;
    typedef logic [COUNT_BITS-1:0] count_t;

    localparam dist_t INF_DIST = {DIST_BITS{1'b1}};
    localparam node_t LAST_ROW = node_t'(MAX_NODES - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SOLVE,
        ST_ANSWER
    } state_t;

    typedef enum logic [2:0] {
        REG_NODE_COUNT = 3'd0
    } reg_addr_t;

    // Controls shared by every cell of the chain.
    typedef struct packed {
        logic  shift;
        logic  relax;
        logic  capture;
        logic  swap;
        node_t wr_row;
        dist_t wr_data;
        node_t rd_row;
    } cell_ctl_t;
endpackage
`default_nettype wire

// ===== hw/rtl/apsp_cell.sv =====
`default_nettype none
// One column of the distance matrix, rotated past its head during a solve.
module apsp_cell (
    input  wire logic               clk,
    input  wire apsp_pkg::cell_ctl_t ctl,
    input  wire logic               col_en,
    input  wire logic               wr_en,
    input  wire logic               k_here,
    input  wire apsp_pkg::dist_t    ik_in,
    input  wire apsp_pkg::dist_t    ik_bus,
    output apsp_pkg::dist_t         ik_out,
    output apsp_pkg::dist_t         rd_data
);
    import apsp_pkg::*;

    dist_t               col_reg [MAX_NODES];
    dist_t               kj_reg;
    dist_t               nkj_reg;
    dist_t               head;
    dist_t               new_head;
    logic [DIST_BITS:0]  sum;
    dist_t               sat;

    assign head    = col_reg[0];
    assign ik_out  = k_here ? head : ik_in;
    assign rd_data = col_reg[ctl.rd_row];

    always_comb
    begin
        sum      = {1'b0, ik_bus} + {1'b0, kj_reg};
        sat      = (sum > {1'b0, INF_DIST}) ? INF_DIST : sum[DIST_BITS-1:0];
        new_head = head;
        if (ctl.relax && col_en && ik_bus != INF_DIST && kj_reg != INF_DIST && sat < head)
        begin
            new_head = sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            for (int m = 0; m < MAX_NODES - 1; m++)
            begin
                col_reg[m] <= col_reg[m+1];
            end
            col_reg[MAX_NODES-1] <= new_head;
            if (ctl.capture)
            begin
                nkj_reg <= new_head;
            end
            if (ctl.swap)
            begin
                kj_reg <= ctl.capture ? new_head : nkj_reg;
            end
        end
        else if (wr_en)
        begin
            col_reg[ctl.wr_row] <= ctl.wr_data;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/all_pairs_shortest_path_unit.sv =====
// Load transfer: no result. Query on a solved matrix: goes straight to the answer state.
// Query after any change: a solve runs first, in which the chain rotates every column
// once per pass, one priming pass plus one pass per intermediate node.
// One item at a time: a new transfer is taken once the previous result has been collected.
// Reset: node_count is 16, a solve is pending, the matrix holds nothing until written.
`default_nettype none
module all_pairs_shortest_path_unit (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic                   action,
    input  wire apsp_pkg::node_t        row_node,
    input  wire apsp_pkg::node_t        col_node,
    input  wire logic [15:0]            edge_weight,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output apsp_pkg::dist_t             distance,
    output logic                        unreachable,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [2:0]             paddr,
    input  wire logic [31:0]            pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import apsp_pkg::*;

    // Control state.
    state_t state_reg, state_next;
    node_t  row_reg, row_next;
    count_t pass_reg, pass_next;
    count_t node_count_reg, node_count_next;
    logic   needs_solve_reg, needs_solve_next;
    logic   out_valid_reg, out_valid_next;

    // Query and result payload.
    node_t  q_row_reg, q_row_next;
    node_t  q_col_reg, q_col_next;
    dist_t  distance_reg, distance_next;
    logic   unreachable_reg, unreachable_next;

    count_t    n_eff;
    logic      in_fire;
    logic      out_fire;
    logic      cfg_write;
    logic      load_ok;
    dist_t     load_value;
    node_t     k_cur;
    cell_ctl_t ctl;
    dist_t     ik_chain [MAX_NODES+1];
    dist_t     rd_col   [MAX_NODES];
    dist_t     answer;

    assign pready    = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign distance  = distance_reg;
    assign unreachable = unreachable_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;
    assign cfg_write = psel && penable && pwrite && pready;

    // A count of zero acts as one node, anything above the matrix size as the full size.
    always_comb
    begin
        if (node_count_reg == '0)
            n_eff = count_t'(1);
        else if (node_count_reg > count_t'(MAX_NODES))
            n_eff = count_t'(MAX_NODES);
        else
            n_eff = node_count_reg;
    end

    // Registers sit on word boundaries, so the register index is the byte address over four.
    assign prdata = ((paddr >> 2) == REG_NODE_COUNT) ? {27'd0, node_count_reg} : 32'd0;

    // A zero weight off the diagonal means there is no edge at all.
    assign load_ok = ({1'b0, row_node} < n_eff) && ({1'b0, col_node} < n_eff);
    always_comb
    begin
        load_value = {{(DIST_BITS-WEIGHT_BITS){1'b0}}, edge_weight};
        if (edge_weight == '0 && row_node != col_node)
        begin
            load_value = INF_DIST;
        end
    end

    // Pass zero only primes the chain with row 0; pass p relaxes through node p-1.
    assign k_cur = node_t'(pass_reg - count_t'(1));

    always_comb
    begin
        ctl.shift   = (state_reg == ST_SOLVE);
        ctl.relax   = (pass_reg != '0) && ({1'b0, row_reg} < n_eff);
        ctl.capture = ({1'b0, row_reg} == pass_reg);
        ctl.swap    = (row_reg == LAST_ROW);
        ctl.wr_row  = row_node;
        ctl.wr_data = load_value;
        ctl.rd_row  = q_row_reg;
    end

    // The row-to-intermediate distance travels down the chain from the cell that holds it.
    assign ik_chain[0] = INF_DIST;

    for (genvar j = 0; j < MAX_NODES; j++)
    begin : g_cell
        apsp_cell u_cell (
            .clk     (clk),
            .ctl     (ctl),
            .col_en  (count_t'(j) < n_eff),
            .wr_en   (in_fire && !action && load_ok && col_node == node_t'(j)),
            .k_here  (k_cur == node_t'(j)),
            .ik_in   (ik_chain[j]),
            .ik_bus  (ik_chain[MAX_NODES]),
            .ik_out  (ik_chain[j+1]),
            .rd_data (rd_col[j])
        );
    end

    always_comb
    begin
        answer = INF_DIST;
        if (({1'b0, q_row_reg} < n_eff) && ({1'b0, q_col_reg} < n_eff))
        begin
            answer = rd_col[q_col_reg];
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        row_next         = row_reg;
        pass_next        = pass_reg;
        node_count_next  = node_count_reg;
        needs_solve_next = needs_solve_reg;
        out_valid_next   = out_valid_reg;
        q_row_next       = q_row_reg;
        q_col_next       = q_col_reg;
        distance_next    = distance_reg;
        unreachable_next = unreachable_reg;

        if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
        if (cfg_write && (paddr >> 2) == REG_NODE_COUNT)
        begin
            node_count_next  = pwdata[COUNT_BITS-1:0];
            needs_solve_next = 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (!action)
                    begin
                        if (load_ok)
                            needs_solve_next = 1'b1;
                    end
                    else
                    begin
                        q_row_next = row_node;
                        q_col_next = col_node;
                        row_next   = '0;
                        pass_next  = '0;
                        state_next = needs_solve_reg ? ST_SOLVE : ST_ANSWER;
                    end
                end
            end
            ST_SOLVE:
            begin
                row_next = row_reg + node_t'(1);
                if (row_reg == LAST_ROW)
                begin
                    pass_next = pass_reg + count_t'(1);
                    if (pass_reg == n_eff)
                    begin
                        needs_solve_next = 1'b0;
                        state_next       = ST_ANSWER;
                    end
                end
            end
            ST_ANSWER:
            begin
                distance_next    = answer;
                unreachable_next = (answer == INF_DIST);
                out_valid_next   = 1'b1;
                state_next       = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            row_reg         <= '0;
            pass_reg        <= '0;
            node_count_reg  <= count_t'(MAX_NODES);
            needs_solve_reg <= 1'b1;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            row_reg         <= row_next;
            pass_reg        <= pass_next;
            node_count_reg  <= node_count_next;
            needs_solve_reg <= needs_solve_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_row_reg       <= q_row_next;
        q_col_reg       <= q_col_next;
        distance_reg    <= distance_next;
        unreachable_reg <= unreachable_next;
    end
endmodule
`default_nettype wire

// ===== hw/rtl/apsp_checker.sv =====
`default_nettype none
`include "all_pairs_shortest_path_unit_macros.svh"
module apsp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [19:0] distance,
    input wire logic        unreachable
);
    `APSP_ASSERT_IMPL(a_no_overlap, clk, rst_n, out_valid, !in_ready)
    `APSP_ASSERT_NEXT(a_result_held, clk, rst_n, out_valid && !out_ready, out_valid && $stable(distance) && $stable(unreachable))
    `APSP_ASSERT_IMPL(a_flag_matches, clk, rst_n, out_valid, unreachable == (distance == 20'hFFFFF))
endmodule

bind all_pairs_shortest_path_unit apsp_checker u_apsp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .distance    (distance),
    .unreachable (unreachable)
);
`default_nettype wire

// ===== tb/all_pairs_shortest_path_unit_tb.sv =====
`default_nettype none
module all_pairs_shortest_path_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import apsp_pkg::*;

    // Action codes carried by the one-bit action field.
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // The settle time before a register write or the final verdict is comfortably
    // above the longest query after a change and any other pending work.
    localparam int SETTLE_CYCLES = 400;
    localparam int HOLD_CYCLES   = 300;
    // Queries only ever run at node counts up to this size, whose square of
    // entries is loaded first.
    localparam int FILL_NODES    = 6;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        action = ACT_LOAD;
    node_t       row_node = '0;
    node_t       col_node = '0;
    logic [15:0] edge_weight = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    dist_t       distance;
    logic        unreachable;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    all_pairs_shortest_path_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .action(action), .row_node(row_node), .col_node(col_node),
        .edge_weight(edge_weight),
        .out_valid(out_valid), .out_ready(out_ready),
        .distance(distance), .unreachable(unreachable),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    typedef struct {
        dist_t dist_val;
        logic  unr;
    } answer_t;

    // Our own copy of the block's state: the distance matrix, the pending
    // solve flag and the node count register.
    dist_t   path_matrix [MAX_NODES*MAX_NODES];
    bit      solve_pending;
    count_t  node_count_reg;
    answer_t pending_answers [$];
    int      fail_count = 0;
    bit      calm = 1'b0;
    bit      hold_req = 1'b0;
    int      hold_left = 0;

    initial
    begin
        forever #4 clk = ~clk;
    end

    // A hard ceiling on the run; a correct run finishes long before this.
    initial
    begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

    // The receiver takes results at random, with calm stretches in which it
    // never idles, and on request holds off for a long stretch so that the
    // block fills and stalls its input.
    always @(posedge clk)
    begin
        if (hold_req && hold_left == 0)
        begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (calm)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(99) >= 19);
    end

    // Outputs only change at a rising edge, so their value at the falling edge
    // is what the next rising edge sees. A result transfer is checked here
    // against the oldest expected answer.
    always @(negedge clk)
    begin
        answer_t exp_ans;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_answers.size() == 0)
            begin
                $error("unexpected result: distance %0d unreachable %0d",
                       distance, unreachable);
                fail_count++;
            end
            else
            begin
                exp_ans = pending_answers.pop_front();
                if (distance !== exp_ans.dist_val)
                begin
                    $error("distance: expected %0d, actual %0d", exp_ans.dist_val, distance);
                    fail_count++;
                end
                if (unreachable !== exp_ans.unr)
                begin
                    $error("unreachable: expected %0d, actual %0d",
                           exp_ans.unr, unreachable);
                    fail_count++;
                end
            end
        end
    end

    // Node count as the block uses it: 0 behaves as 1, anything above the
    // maximum behaves as the maximum.
    function automatic int active_nodes();
        if (node_count_reg == 0)
            return 1;
        if (node_count_reg > MAX_NODES)
            return MAX_NODES;
        return int'(node_count_reg);
    endfunction

    // In-place Floyd-Warshall relaxation with sums saturating at infinity.
    function automatic void relax_all(int n);
        dist_t    ik;
        dist_t    kj;
        bit [20:0] sum;
        for (int k = 0; k < n; k++)
            for (int i = 0; i < n; i++)
            begin
                ik = path_matrix[i*MAX_NODES + k];
                if (ik != INF_DIST)
                    for (int j = 0; j < n; j++)
                    begin
                        kj = path_matrix[k*MAX_NODES + j];
                        if (kj != INF_DIST)
                        begin
                            sum = ik + kj;
                            if (sum > INF_DIST)
                                sum = INF_DIST;
                            if (sum[19:0] < path_matrix[i*MAX_NODES + j])
                                path_matrix[i*MAX_NODES + j] = sum[19:0];
                        end
                    end
            end
    endfunction

    // Applies one accepted input transfer to our copy of the state and, for a
    // query, queues the answer that the block must return.
    function automatic void apply_item(logic act, node_t r, node_t c, logic [15:0] w);
        int      n;
        dist_t   stored;
        answer_t ans;
        n = active_nodes();
        if (act == ACT_LOAD)
        begin
            if (r < n && c < n)
            begin
                // An off-diagonal zero means there is no edge at all.
                stored = dist_t'(w);
                if (w == 0 && r != c)
                    stored = INF_DIST;
                path_matrix[r*MAX_NODES + c] = stored;
                solve_pending = 1'b1;
            end
        end
        else
        begin
            if (solve_pending)
            begin
                relax_all(n);
                solve_pending = 1'b0;
            end
            ans.dist_val = INF_DIST;
            if (r < n && c < n)
                ans.dist_val = path_matrix[r*MAX_NODES + c];
            ans.unr = (ans.dist_val == INF_DIST);
            pending_answers = {pending_answers, ans};
        end
    endfunction

    // Offers one item and waits for its transfer. Valid is only lowered for a
    // random gap; an item that follows straight on keeps valid high.
    task automatic send_item(logic act, node_t r, node_t c, logic [15:0] w);
        logic rdy;
        int   gap;
        if (!calm && $urandom_range(99) < 19)
        begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        action      <= act;
        row_node    <= r;
        col_node    <= c;
        edge_weight <= w;
        do
        begin
            @(negedge clk);
            rdy = in_ready;
            @(posedge clk);
        end
        while (!rdy);
        apply_item(act, r, c, w);
    endtask

    // Lets the block go idle: every answer in, then the settle time.
    task automatic wait_idle();
        in_valid <= 1'b0;
        wait (pending_answers.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes the node count through the register port once the block is idle.
    task automatic write_node_count(logic [31:0] value);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(REG_NODE_COUNT) << 2;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        node_count_reg = count_t'(value);
        solve_pending  = 1'b1;
    endtask

    function automatic logic [15:0] pick_weight();
        case ($urandom_range(9))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2, 3, 4: return 16'($urandom_range(1, 40));
            default: return 16'($urandom);
        endcase
    endfunction

    // Every entry of the square that queries work over is written first, so
    // that no relaxation ever reads an entry that was never loaded.
    task automatic test_fill_matrix();
        write_node_count(32'(FILL_NODES));
        for (int i = 0; i < FILL_NODES; i++)
            for (int j = 0; j < FILL_NODES; j++)
                send_item(ACT_LOAD, node_t'(i), node_t'(j),
                          (i == j) ? 16'd0 : pick_weight());
    endtask

    // Directed cases: extremes of the fields, a diagonal weight kept as
    // given, a load after a solve, a chain of the heaviest weights, and
    // loads and queries beyond the active node count.
    task automatic test_directed();
        send_item(ACT_QUERY, 4'd0, 4'd15, 16'd0);
        send_item(ACT_QUERY, 4'd15, 4'd0, 16'hFFFF);
        send_item(ACT_QUERY, 4'd2, 4'd2, 16'd0);
        send_item(ACT_LOAD, 4'd3, 4'd3, 16'd5);
        send_item(ACT_QUERY, 4'd3, 4'd3, 16'd0);
        for (int i = 0; i < FILL_NODES - 1; i++)
            send_item(ACT_LOAD, node_t'(i), node_t'(i + 1), 16'hFFFF);
        send_item(ACT_QUERY, 4'd0, node_t'(FILL_NODES - 1), 16'd0);
        send_item(ACT_LOAD, 4'd0, node_t'(FILL_NODES - 1), 16'd0);
        send_item(ACT_QUERY, 4'd0, node_t'(FILL_NODES - 1), 16'd0);
        write_node_count(32'd4);
        send_item(ACT_LOAD, 4'd9, 4'd1, 16'd1);
        send_item(ACT_QUERY, 4'd1, 4'd9, 16'd0);
        send_item(ACT_QUERY, 4'd2, 4'd1, 16'd0);
    endtask

    // Node counts at both extremes and beyond them, each followed by loads;
    // counts small enough for the loaded square are also queried.
    task automatic test_node_counts();
        logic [31:0] counts [6];
        counts = '{32'd1, 32'd16, 32'd0, 32'd31, 32'd2, 32'd17};
        foreach (counts[k])
        begin
            write_node_count(counts[k]);
            for (int i = 0; i < 2; i++)
                send_item(ACT_LOAD, node_t'($urandom_range(15)),
                          node_t'($urandom_range(15)), pick_weight());
            if (active_nodes() <= FILL_NODES)
                send_item(ACT_QUERY, 4'd0, 4'd1, 16'd0);
            else
                send_item(ACT_LOAD, node_t'($urandom_range(15)),
                          node_t'($urandom_range(15)), pick_weight());
        end
    endtask

    // Random traffic, mostly over the loaded nodes, at several node counts.
    task automatic test_random();
        int n;
        for (int i = 0; i < 60; i++)
        begin
            if (i % 20 == 0)
                write_node_count(32'($urandom_range(1, FILL_NODES)));
            if (i == 25)
                calm = 1'b1;
            if (i == 45)
                calm = 1'b0;
            n = active_nodes();
            if ($urandom_range(99) < 60)
                send_item(ACT_LOAD,
                          node_t'($urandom_range(99) < 90 ? $urandom_range(n - 1)
                                                          : $urandom_range(15)),
                          node_t'($urandom_range(n - 1)), pick_weight());
            else
                send_item(ACT_QUERY,
                          node_t'($urandom_range(99) < 90 ? $urandom_range(n - 1)
                                                          : $urandom_range(15)),
                          node_t'($urandom_range(99) < 90 ? $urandom_range(n - 1)
                                                          : $urandom_range(15)),
                          16'($urandom));
        end
    endtask

    // The receiver holds off while the sender keeps offering queries, which
    // stalls the input; afterwards the sender pauses until every answer has
    // come before carrying on.
    task automatic test_back_pressure();
        write_node_count(32'(FILL_NODES));
        send_item(ACT_LOAD, 4'd4, 4'd5, 16'd3);
        hold_req = 1'b1;
        for (int i = 0; i < 6; i++)
            send_item(ACT_QUERY, node_t'($urandom_range(15)),
                      node_t'($urandom_range(15)), 16'd0);
        in_valid <= 1'b0;
        wait (pending_answers.size() == 0);
        @(posedge clk);
        for (int i = 0; i < 4; i++)
            send_item(ACT_QUERY, node_t'($urandom_range(15)),
                      node_t'($urandom_range(15)), 16'd0);
    endtask

    initial
    begin
        node_count_reg = count_t'(MAX_NODES);
        solve_pending  = 1'b1;
        foreach (path_matrix[i])
            path_matrix[i] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fill_matrix();
        test_directed();
        test_node_counts();
        test_random();
        test_back_pressure();

        // All stimulus is in; wait for the last answers and a quiet spell.
        in_valid <= 1'b0;
        wait (pending_answers.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_answers.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/apsp_pkg.sv
hw/rtl/apsp_cell.sv
hw/rtl/all_pairs_shortest_path_unit.sv
hw/rtl/apsp_checker.sv
tb/all_pairs_shortest_path_unit_tb.sv
